FILE: rtl/lpr_pkg.sv
package lpr_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int KEY_BITS      = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int LEN_W         = 7;
	localparam int HOP_W         = 64;
	localparam int EN_IDX_W      = $clog2(KEY_BITS);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(KEY_BITS);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_LEN_OFF = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_LOOKUP,
		CMD_INSERT,
		CMD_DEFAULT,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [KEY_BITS-1:0] key;
		logic [LEN_W-1:0]    len;
		logic [HOP_W-1:0]    hop_hi;
		logic [HOP_W-1:0]    hop_lo;
	} cmd_t;

	typedef struct packed {
		logic                valid;
		logic [LEN_W-1:0]    len;
		logic [KEY_BITS-1:0] key;
		logic [HOP_W-1:0]    hop_hi;
		logic [HOP_W-1:0]    hop_lo;
	} entry_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEN,
		ST_RD,
		ST_CMP
	} back_state_t;

	// keep the top len bits of a key
	function automatic logic [KEY_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [KEY_BITS-1:0] m;
		m = ~({KEY_BITS{1'b1}} >> len);
		return m;
	endfunction

	// fold key and length into a table slot
	function automatic logic [IDX_W-1:0] slot_hash(input logic [KEY_BITS-1:0] key,
		input logic [LEN_W-1:0] len);
		logic [IDX_W-1:0] h;
		h = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			h[i % IDX_W] = h[i % IDX_W] ^ key[i];
		end
		for (int j = 0; j < LEN_W; j++) begin
			h[(j * 3 + 1) % IDX_W] = h[(j * 3 + 1) % IDX_W] ^ len[j];
		end
		return h;
	endfunction

endpackage

FILE: rtl/lpr_in_if.sv
interface lpr_in_if;
	logic                            valid;
	logic                            ready;
	logic                            op;
	logic [lpr_pkg::KEY_BITS-1:0]    addr_key;
	logic [lpr_pkg::LEN_W-1:0]       prefix_len;
	logic [lpr_pkg::HOP_W-1:0]       hop_in_hi;
	logic [lpr_pkg::HOP_W-1:0]       hop_in_lo;

	modport source (output valid, op, addr_key, prefix_len, hop_in_hi, hop_in_lo,
		input ready);
	modport sink (input valid, op, addr_key, prefix_len, hop_in_hi, hop_in_lo,
		output ready);
endinterface

FILE: rtl/lpr_out_if.sv
interface lpr_out_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [lpr_pkg::HOP_W-1:0]  hop_out_hi;
	logic [lpr_pkg::HOP_W-1:0]  hop_out_lo;
	logic                       created;
	logic [1:0]                 status;

	modport source (output valid, found, hop_out_hi, hop_out_lo, created, status,
		input ready);
	modport sink (input valid, found, hop_out_hi, hop_out_lo, created, status,
		output ready);
endinterface

FILE: rtl/lpr_front.sv
module lpr_front (
	lpr_in_if.sink                       in_ch,
	input  logic [lpr_pkg::KEY_BITS-1:0] enabled_lengths,
	input  logic                         fifo_full,
	input  lpr_pkg::back_stat_t          stat,
	output logic                         push,
	output lpr_pkg::cmd_t                cmd
);

	logic [lpr_pkg::LEN_W-1:0] len_gap;

	// accept while the queue has room and the table is cleared
	assign in_ch.ready = !fifo_full && !stat.clearing;
	assign push        = in_ch.valid && in_ch.ready;
	assign len_gap     = lpr_pkg::MAX_LEN - in_ch.prefix_len;

	// classify the transaction
	always_comb begin
		cmd.key    = in_ch.addr_key;
		cmd.len    = in_ch.prefix_len;
		cmd.hop_hi = in_ch.hop_in_hi;
		cmd.hop_lo = in_ch.hop_in_lo;
		if (in_ch.op == lpr_pkg::OP_LOOKUP) begin
			cmd.kind = lpr_pkg::CMD_LOOKUP;
		end else if (in_ch.prefix_len == '0) begin
			cmd.kind = lpr_pkg::CMD_DEFAULT;
		end else if (in_ch.prefix_len > lpr_pkg::MAX_LEN ||
				!enabled_lengths[len_gap[lpr_pkg::EN_IDX_W-1:0]]) begin
			cmd.kind = lpr_pkg::CMD_REJECT;
		end else begin
			cmd.kind = lpr_pkg::CMD_INSERT;
			cmd.key  = in_ch.addr_key & lpr_pkg::len_mask(in_ch.prefix_len);
		end
	end

endmodule

FILE: rtl/lpr_fifo.sv
module lpr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output lpr_pkg::cmd_t head
);

	lpr_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/lpr_back.sv
module lpr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lpr_pkg::KEY_BITS-1:0] enabled_lengths,
	input  logic                         cmd_valid,
	input  lpr_pkg::cmd_t                cmd,
	output logic                         pop,
	output lpr_pkg::back_stat_t          stat,
	lpr_out_if.source                    out_ch
);

	lpr_pkg::entry_t mem [lpr_pkg::TABLE_ENTRIES];

	lpr_pkg::back_state_t             state_q, state_d;
	logic [lpr_pkg::IDX_W-1:0]        clr_q;
	lpr_pkg::cmd_t                    cmd_q;
	logic [lpr_pkg::LEN_W-1:0]        len_q;
	logic [lpr_pkg::KEY_BITS-1:0]     key_q;
	logic [lpr_pkg::IDX_W-1:0]        slot_q;
	logic [lpr_pkg::IDX_W-1:0]        probe_q;
	lpr_pkg::entry_t                  rd_q;
	logic                             def_present_q;
	logic [lpr_pkg::HOP_W-1:0]        def_hi_q;
	logic [lpr_pkg::HOP_W-1:0]        def_lo_q;
	logic                             out_valid_q;
	logic                             found_q;
	logic [lpr_pkg::HOP_W-1:0]        hop_hi_q;
	logic [lpr_pkg::HOP_W-1:0]        hop_lo_q;
	logic                             created_q;
	lpr_pkg::status_t                 status_q;

	logic                             is_lookup;
	logic                             hit;
	logic                             empty;
	logic                             last;
	logic                             len_on;
	logic [lpr_pkg::LEN_W-1:0]        len_gap;
	logic [lpr_pkg::KEY_BITS-1:0]     probe_key;
	logic                             mem_we;
	logic [lpr_pkg::IDX_W-1:0]        mem_addr;
	lpr_pkg::entry_t                  mem_wdata;

	assign is_lookup = cmd_q.kind == lpr_pkg::CMD_LOOKUP;
	assign hit       = rd_q.valid && rd_q.len == len_q && rd_q.key == key_q;
	assign empty     = !rd_q.valid;
	assign last      = probe_q == '1;
	assign len_gap   = lpr_pkg::MAX_LEN - len_q;
	assign len_on    = enabled_lengths[len_gap[lpr_pkg::EN_IDX_W-1:0]];
	assign probe_key = cmd_q.key & lpr_pkg::len_mask(len_q);
	assign pop       = state_q == lpr_pkg::ST_IDLE && cmd_valid && !out_valid_q;
	assign stat.clearing = state_q == lpr_pkg::ST_CLEAR;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.found      = found_q;
	assign out_ch.hop_out_hi = hop_hi_q;
	assign out_ch.hop_out_lo = hop_lo_q;
	assign out_ch.created    = created_q;
	assign out_ch.status     = status_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpr_pkg::ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = lpr_pkg::ST_IDLE;
				end
			end
			lpr_pkg::ST_IDLE: begin
				if (pop) begin
					if (cmd.kind == lpr_pkg::CMD_LOOKUP) begin
						state_d = lpr_pkg::ST_LEN;
					end else if (cmd.kind == lpr_pkg::CMD_INSERT) begin
						state_d = lpr_pkg::ST_RD;
					end
				end
			end
			lpr_pkg::ST_LEN: begin
				if (len_q == '0) begin
					state_d = lpr_pkg::ST_IDLE;
				end else if (len_on) begin
					state_d = lpr_pkg::ST_RD;
				end
			end
			lpr_pkg::ST_RD: begin
				state_d = lpr_pkg::ST_CMP;
			end
			lpr_pkg::ST_CMP: begin
				if (is_lookup) begin
					if (hit) begin
						state_d = lpr_pkg::ST_IDLE;
					end else if (empty || last) begin
						state_d = lpr_pkg::ST_LEN;
					end else begin
						state_d = lpr_pkg::ST_RD;
					end
				end else if (hit || empty || last) begin
					state_d = lpr_pkg::ST_IDLE;
				end else begin
					state_d = lpr_pkg::ST_RD;
				end
			end
			default: state_d = lpr_pkg::ST_CLEAR;
		endcase
	end

	// table write port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = slot_q;
		mem_wdata = '{valid: 1'b1, len: len_q, key: key_q,
			hop_hi: cmd_q.hop_hi, hop_lo: cmd_q.hop_lo};
		unique case (state_q)
			lpr_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			lpr_pkg::ST_CMP: begin
				mem_we = !is_lookup && (hit || empty);
			end
			default: mem_we = 1'b0;
		endcase
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[slot_q];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lpr_pkg::ST_CLEAR;
			clr_q         <= '0;
			def_present_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpr_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				lpr_pkg::ST_IDLE: begin
					if (pop && (cmd.kind == lpr_pkg::CMD_DEFAULT ||
							cmd.kind == lpr_pkg::CMD_REJECT)) begin
						out_valid_q <= 1'b1;
					end
					if (pop && cmd.kind == lpr_pkg::CMD_DEFAULT) begin
						def_present_q <= 1'b1;
					end
				end
				lpr_pkg::ST_LEN: begin
					if (len_q == '0) begin
						out_valid_q <= 1'b1;
					end
				end
				lpr_pkg::ST_CMP: begin
					if ((is_lookup && hit) || (!is_lookup && (hit || empty || last))) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			lpr_pkg::ST_IDLE: begin
				if (pop) begin
					cmd_q     <= cmd;
					key_q     <= cmd.key;
					slot_q    <= lpr_pkg::slot_hash(cmd.key, cmd.len);
					probe_q   <= '0;
					found_q   <= 1'b0;
					hop_hi_q  <= '0;
					hop_lo_q  <= '0;
					created_q <= cmd.kind == lpr_pkg::CMD_DEFAULT && !def_present_q;
					status_q  <= (cmd.kind == lpr_pkg::CMD_REJECT) ?
						lpr_pkg::STAT_LEN_OFF : lpr_pkg::STAT_OK;
					len_q     <= (cmd.kind == lpr_pkg::CMD_LOOKUP) ? lpr_pkg::MAX_LEN : cmd.len;
					if (cmd.kind == lpr_pkg::CMD_DEFAULT) begin
						def_hi_q  <= cmd.hop_hi;
						def_lo_q  <= cmd.hop_lo;
					end
				end
			end
			lpr_pkg::ST_LEN: begin
				if (len_q == '0) begin
					found_q <= def_present_q;
					if (def_present_q) begin
						hop_hi_q <= def_hi_q;
						hop_lo_q <= def_lo_q;
					end
				end else if (len_on) begin
					key_q   <= probe_key;
					slot_q  <= lpr_pkg::slot_hash(probe_key, len_q);
					probe_q <= '0;
				end else begin
					len_q <= len_q - 1'b1;
				end
			end
			lpr_pkg::ST_CMP: begin
				if (is_lookup) begin
					if (hit) begin
						found_q  <= 1'b1;
						hop_hi_q <= rd_q.hop_hi;
						hop_lo_q <= rd_q.hop_lo;
					end else if (empty || last) begin
						len_q <= len_q - 1'b1;
					end else begin
						slot_q  <= slot_q + 1'b1;
						probe_q <= probe_q + 1'b1;
					end
				end else if (hit) begin
					created_q <= 1'b0;
				end else if (empty) begin
					created_q <= 1'b1;
				end else if (last) begin
					status_q <= lpr_pkg::STAT_FULL;
				end else begin
					slot_q  <= slot_q + 1'b1;
					probe_q <= probe_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/ipv6_longest_prefix_route_table_unit.sv
// channel  | role | handshake     | payload
// in_ch    | sink | valid / ready | op, addr_key, prefix_len, hop_in_hi, hop_in_lo
// out_ch   | src  | valid / ready | found, hop_out_hi, hop_out_lo, created, status
// cfg      | wr   | cfg_we        | cfg_wdata -> enabled_lengths
// after reset a clearing pass over all 1024 entries empties the table; no input taken meanwhile.
// default route and rejected inserts are answered without a table access; a table insert
// probes linearly from the hashed slot of its length and key. a lookup probes the same way
// at each enabled length, walking lengths 64 down to 1 through the single table read port.
// a two-deep queue lets the input side keep accepting while the back end probes.
module ipv6_longest_prefix_route_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	lpr_in_if.sink                       in_ch,
	lpr_out_if.source                    out_ch,
	input  logic                         cfg_we,
	input  logic [lpr_pkg::KEY_BITS-1:0] cfg_wdata
);

	logic [lpr_pkg::KEY_BITS-1:0] enabled_q;
	lpr_pkg::back_stat_t          stat;
	lpr_pkg::cmd_t                push_cmd;
	lpr_pkg::cmd_t                head;
	logic                         push;
	logic                         pop;
	logic                         fifo_full;
	logic                         not_empty;

	// enabled lengths register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '1;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	lpr_front u_front (
		.in_ch           (in_ch),
		.enabled_lengths (enabled_q),
		.fifo_full       (fifo_full),
		.stat            (stat),
		.push            (push),
		.cmd             (push_cmd)
	);

	lpr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (fifo_full),
		.not_empty (not_empty),
		.head      (head)
	);

	lpr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.enabled_lengths (enabled_q),
		.cmd_valid       (not_empty),
		.cmd             (head),
		.pop             (pop),
		.stat            (stat),
		.out_ch          (out_ch)
	);

	// no result while the table is being cleared
	a_no_out_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !out_ch.valid)
		else $error("result during clearing pass");

	// no transaction taken while the table is being cleared
	a_no_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !in_ch.ready)
		else $error("input taken during clearing pass");

	// a delivered result is never followed directly by another
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready) |=> !out_ch.valid)
		else $error("result register reloaded while busy");

endmodule

FILE: tb/sv/lpr_route_checker.sv
`timescale 1ns / 100ps

module lpr_route_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	lpr_in_if                            in_ch,
	lpr_out_if                           out_ch,
	input  logic                         cfg_we,
	input  logic [lpr_pkg::KEY_BITS-1:0] cfg_wdata,
	output int                           fail_count,
	output int                           pending
);

	typedef struct packed {
		logic                      found;
		logic [lpr_pkg::HOP_W-1:0] hop_hi;
		logic [lpr_pkg::HOP_W-1:0] hop_lo;
		logic                      created;
		lpr_pkg::status_t          status;
	} route_result_t;

	route_result_t                                   result_q[$];
	logic [lpr_pkg::KEY_BITS-1:0]                    len_enable;
	logic [2*lpr_pkg::HOP_W-1:0]
		route_hop[logic [lpr_pkg::LEN_W+lpr_pkg::KEY_BITS-1:0]];
	logic                                            default_valid;
	logic [2*lpr_pkg::HOP_W-1:0]                     default_hop;

	assign pending = result_q.size();

	// top l bits of a key, l in 1..64
	function automatic logic [lpr_pkg::KEY_BITS-1:0] prefix_mask(input int l);
		return {lpr_pkg::KEY_BITS{1'b1}} << (lpr_pkg::KEY_BITS - l);
	endfunction

	// next state of the route table and the answer for one transaction
	function automatic route_result_t route_answer(input logic op,
		input logic [lpr_pkg::KEY_BITS-1:0] key, input logic [lpr_pkg::LEN_W-1:0] len,
		input logic [lpr_pkg::HOP_W-1:0] hi, input logic [lpr_pkg::HOP_W-1:0] lo);
		route_result_t r;
		logic [lpr_pkg::LEN_W+lpr_pkg::KEY_BITS-1:0] tag;
		int l;
		r = '0;
		r.status = lpr_pkg::STAT_OK;
		if (op == lpr_pkg::OP_INSERT) begin
			if (len == 0) begin
				r.created = !default_valid;
				default_valid = 1'b1;
				default_hop = {hi, lo};
			end else if (len > lpr_pkg::MAX_LEN ||
					!len_enable[lpr_pkg::KEY_BITS - int'(len)]) begin
				r.status = lpr_pkg::STAT_LEN_OFF;
			end else begin
				tag = {len, key & prefix_mask(int'(len))};
				if (route_hop.exists(tag)) begin
					route_hop[tag] = {hi, lo};
				end else if (route_hop.num() >= lpr_pkg::TABLE_ENTRIES) begin
					r.status = lpr_pkg::STAT_FULL;
				end else begin
					route_hop[tag] = {hi, lo};
					r.created = 1'b1;
				end
			end
		end else begin
			// longest enabled length first
			for (l = lpr_pkg::KEY_BITS; l >= 1 && !r.found; l--) begin
				tag = {lpr_pkg::LEN_W'(l), key & prefix_mask(l)};
				if (len_enable[lpr_pkg::KEY_BITS - l] && route_hop.exists(tag)) begin
					r.found = 1'b1;
					{r.hop_hi, r.hop_lo} = route_hop[tag];
				end
			end
			if (!r.found && default_valid) begin
				r.found = 1'b1;
				{r.hop_hi, r.hop_lo} = default_hop;
			end
		end
		return r;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		route_result_t exp_r;
		route_result_t act_r;
		if (!arst_n) begin
			len_enable = '1;
			route_hop.delete();
			default_valid = 1'b0;
			default_hop = '0;
			result_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				len_enable = cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				result_q.push_back(route_answer(in_ch.op, in_ch.addr_key, in_ch.prefix_len,
					in_ch.hop_in_hi, in_ch.hop_in_lo));
			if (out_ch.valid && out_ch.ready) begin
				act_r.found = out_ch.found;
				act_r.hop_hi = out_ch.hop_out_hi;
				act_r.hop_lo = out_ch.hop_out_lo;
				act_r.created = out_ch.created;
				act_r.status = lpr_pkg::status_t'(out_ch.status);
				if (result_q.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result: found %b hop %h_%h created %b status %0d",
						$time, act_r.found, act_r.hop_hi, act_r.hop_lo, act_r.created,
						act_r.status);
				end else begin
					exp_r = result_q.pop_front();
					if (act_r.found !== exp_r.found || act_r.hop_hi !== exp_r.hop_hi ||
						act_r.hop_lo !== exp_r.hop_lo || act_r.created !== exp_r.created ||
						act_r.status !== exp_r.status) begin
						fail_count++;
						$display("%0t mismatch: expected found %b hop %h_%h created %b status %0d",
							$time, exp_r.found, exp_r.hop_hi, exp_r.hop_lo, exp_r.created,
							exp_r.status);
						$display("%0t           actual found %b hop %h_%h created %b status %0d",
							$time, act_r.found, act_r.hop_hi, act_r.hop_lo, act_r.created,
							act_r.status);
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb_ipv6_longest_prefix_route_table_unit.sv
`timescale 1ns / 100ps

module tb_ipv6_longest_prefix_route_table_unit;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [lpr_pkg::KEY_BITS-1:0] cfg_wdata;
	int                           fail_count;
	int                           pending;
	bit                           quiet;
	bit                           long_hold;
	logic [lpr_pkg::KEY_BITS-1:0] pool_key[$];
	logic [lpr_pkg::LEN_W-1:0]    pool_len[$];

	lpr_in_if  in_ch ();
	lpr_out_if out_ch ();

	ipv6_longest_prefix_route_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lpr_route_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial begin
		#40ms;
		$display("ipv6_longest_prefix_route_table_unit verification failed");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// offer one transaction and hold it until accepted
	task automatic send_item(input logic op, input logic [lpr_pkg::KEY_BITS-1:0] key,
		input logic [lpr_pkg::LEN_W-1:0] len, input logic [lpr_pkg::HOP_W-1:0] hi,
		input logic [lpr_pkg::HOP_W-1:0] lo);
		bit taken;
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.addr_key <= key;
		in_ch.prefix_len <= len;
		in_ch.hop_in_hi <= hi;
		in_ch.hop_in_lo <= lo;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
		if (op == lpr_pkg::OP_INSERT && len != 0 && len <= lpr_pkg::MAX_LEN) begin
			pool_key.push_back(key);
			pool_len.push_back(len);
		end
		// sender idle burst
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// wait until every result is back
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_enables(input logic [lpr_pkg::KEY_BITS-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random route traffic, biased toward known prefixes
	task automatic random_item();
		int i;
		logic [lpr_pkg::LEN_W-1:0] len;
		logic [lpr_pkg::KEY_BITS-1:0] key;
		if ($urandom_range(0, 99) < 45) begin
			case ($urandom_range(0, 19))
				0: len = 0;
				1: len = lpr_pkg::LEN_W'($urandom_range(65, 127));
				2, 3, 4, 5, 6: len = lpr_pkg::LEN_W'(8 * $urandom_range(1, 8));
				default: len = lpr_pkg::LEN_W'($urandom_range(1, 64));
			endcase
			key = rand64();
			if (pool_key.size() != 0 && $urandom_range(0, 2) == 0) begin
				i = $urandom_range(0, pool_key.size() - 1);
				len = pool_len[i];
				key = pool_key[i] | (rand64() & ({lpr_pkg::KEY_BITS{1'b1}} >> len));
			end
			send_item(lpr_pkg::OP_INSERT, key, len, rand64(), rand64());
		end else begin
			key = rand64();
			if (pool_key.size() != 0 && $urandom_range(0, 9) < 7) begin
				i = $urandom_range(0, pool_key.size() - 1);
				key = pool_key[i] | (rand64() & ({lpr_pkg::KEY_BITS{1'b1}} >> pool_len[i]));
			end
			send_item(lpr_pkg::OP_LOOKUP, key, lpr_pkg::LEN_W'($urandom()), rand64(), rand64());
		end
	endtask

	// receiver stalls
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				for (int c = 0; c < 400; c++) @(posedge clk);
				long_hold = 1'b0;
			end else if (quiet) begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = lpr_pkg::OP_INSERT;
		in_ch.addr_key = '0;
		in_ch.prefix_len = '0;
		in_ch.hop_in_hi = '0;
		in_ch.hop_in_lo = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, default route, length extremes, updates
		send_item(lpr_pkg::OP_LOOKUP, '1, '0, '0, '0);
		send_item(lpr_pkg::OP_INSERT, '0, 7'd0, '1, '1);
		send_item(lpr_pkg::OP_LOOKUP, 64'h0123_4567_89ab_cdef, '0, '0, '0);
		send_item(lpr_pkg::OP_INSERT, '0, 7'd0, 64'h2001_0db8_0000_0001, '0);
		send_item(lpr_pkg::OP_INSERT, '1, 7'd64, '1, '0);
		send_item(lpr_pkg::OP_INSERT, '1, 7'd1, '0, '1);
		send_item(lpr_pkg::OP_INSERT, '0, 7'd32, 64'h1, 64'h2);
		send_item(lpr_pkg::OP_INSERT, '1, 7'd65, '1, '1);
		send_item(lpr_pkg::OP_INSERT, '1, 7'd127, '1, '1);
		send_item(lpr_pkg::OP_LOOKUP, '1, '1, '1, '1);
		send_item(lpr_pkg::OP_LOOKUP, 64'hfffffffffffffffe, '0, '0, '0);
		send_item(lpr_pkg::OP_LOOKUP, 64'h0000_0000_ffff_ffff, '0, '0, '0);
		send_item(lpr_pkg::OP_LOOKUP, 64'h0000_0001_0000_0000, '0, '0, '0);
		send_item(lpr_pkg::OP_INSERT, '1, 7'd64, 64'h5555_5555_5555_5555,
			64'haaaa_aaaa_aaaa_aaaa);
		send_item(lpr_pkg::OP_LOOKUP, '1, '0, '0, '0);
		send_item(lpr_pkg::OP_INSERT, 64'hffff_ffff_0000_0000, 7'd32, 64'h3, 64'h4);
		send_item(lpr_pkg::OP_LOOKUP, 64'hffff_ffff_1234_5678, '0, '0, '0);
		send_item(lpr_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 7'd1, 64'h7, 64'h8);
		send_item(lpr_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, '0, '0, '0);
		settle();

		// random enables, with one long receiver hold-off
		write_enables(rand64());
		for (int n = 0; n < 120; n++) begin
			if (n == 40)
				long_hold = 1'b1;
			random_item();
		end
		settle();

		// every length disabled: only the default route answers
		write_enables('0);
		for (int n = 0; n < 20; n++)
			random_item();
		settle();

		write_enables(64'haaaa_aaaa_aaaa_aaaa);
		for (int n = 0; n < 40; n++)
			random_item();
		settle();

		write_enables('1);
		for (int n = 0; n < 90; n++)
			random_item();
		settle();

		// fill the table with host routes until inserts are dropped
		for (int n = 0; n < 1024; n++)
			send_item(lpr_pkg::OP_INSERT, rand64(), 7'd64, rand64(), rand64());
		for (int n = 0; n < 8; n++)
			send_item(lpr_pkg::OP_INSERT, rand64(), lpr_pkg::LEN_W'($urandom_range(1, 64)),
				rand64(), rand64());
		for (int n = 0; n < 6; n++) begin
			int i;
			i = $urandom_range(0, pool_key.size() - 1);
			send_item(lpr_pkg::OP_INSERT, pool_key[i], pool_len[i], rand64(), rand64());
		end
		send_item(lpr_pkg::OP_INSERT, rand64(), 7'd0, rand64(), rand64());
		settle();

		// last part without idling: only host routes searched
		quiet = 1'b1;
		repeat (32) @(posedge clk);
		write_enables(64'h1);
		for (int n = 0; n < 20; n++) begin
			int i;
			i = $urandom_range(0, pool_key.size() - 1);
			send_item(lpr_pkg::OP_LOOKUP, (n % 4 == 0) ? rand64() : pool_key[i], '0, '0, '0);
		end
		settle();

		if (fail_count == 0)
			$display("ipv6_longest_prefix_route_table_unit verification clean");
		else
			$display("ipv6_longest_prefix_route_table_unit verification failed");
		$finish;
	end

endmodule
